### rtl/uimp_pkg.sv
package uimp_pkg;

	localparam int NUM_USERS = 1024;
	localparam int NUM_ITEMS = 4096;
	localparam int USER_AW   = $clog2(NUM_USERS);
	localparam int ITEM_AW   = $clog2(NUM_ITEMS);

	localparam int CLR_N = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS;
	localparam int CLR_W = $clog2(CLR_N);

	localparam int DIV_STEPS = 16;
	localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [23:0] GCOUNT_MAX = 24'hFF_FFFF;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	typedef enum logic [1:0] {
		RES_ADD_OK,
		RES_REFUSED,
		RES_EMPTY,
		RES_PRED
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     clear_step;
		logic     write_add;
		logic     div_start;
		logic     res_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_query;
		logic refuse;
		logic gcount_zero;
		logic div_done;
	} stat_t;

	typedef struct packed {
		logic [31:0] sum;
		logic [15:0] cnt;
	} entry_t;

endpackage

### rtl/user_item_mean_predictor.sv
// channel  | signals                                    | handshake
// ---------+--------------------------------------------+---------------------------
// input    | op, user_index, item_index, rating         | taken when start && !busy
// result   | prediction, status                         | valid one cycle, done high
//
// Add: at acceptance both stores are read, then state LOOK does the read-modify-write and raises done.
// Query: after state LOOK, three 16-step restoring dividers (global, user, item means) run in parallel in state DIV.
// Early query answers (no ratings yet) are given from state LOOK without dividing.
// After reset a clearing pass zeroes every entry of both stores; busy stays high meanwhile.
// The receiver cannot stall; each result is presented for exactly one cycle.
module user_item_mean_predictor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        op,
	input  logic [9:0]  user_index,
	input  logic [11:0] item_index,
	input  logic [15:0] rating,
	output logic        busy,
	output logic        done,
	output logic [15:0] prediction,
	output logic [1:0]  status
);

	uimp_pkg::cmd_t  cmd;
	uimp_pkg::stat_t stat;

	uimp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	uimp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op         (op),
		.user_index (user_index),
		.item_index (item_index),
		.rating     (rating),
		.stat       (stat),
		.prediction (prediction),
		.status     (status)
	);

endmodule

### rtl/uimp_div.sv
module uimp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [23:0] divisor,
	output logic [15:0] quotient,
	output logic        done
);

	logic [23:0]                   rem_q;
	logic [15:0]                   quo_q;
	logic [uimp_pkg::DIV_CW-1:0]   cnt_q;
	logic                          done_q;
	logic [24:0]                   trial;
	logic [24:0]                   diff;
	logic                          ge;

	// quotient always fits 16 bits, so the top 24 dividend bits start below the divisor
	assign trial = {rem_q, quo_q[15]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= uimp_pkg::DIV_CW'(uimp_pkg::DIV_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - uimp_pkg::DIV_CW'(1);
			done_q <= (cnt_q == uimp_pkg::DIV_CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[39:16];
			quo_q <= dividend[15:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[23:0] : trial[23:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### rtl/uimp_datapath.sv
module uimp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  uimp_pkg::cmd_t       cmd,
	input  logic                 op,
	input  logic [9:0]           user_index,
	input  logic [11:0]          item_index,
	input  logic [15:0]          rating,
	output uimp_pkg::stat_t      stat,
	output logic [15:0]          prediction,
	output logic [1:0]           status
);

	uimp_pkg::entry_t user_mem [uimp_pkg::NUM_USERS];
	uimp_pkg::entry_t item_mem [uimp_pkg::NUM_ITEMS];

	logic                          op_q;
	logic [9:0]                    uidx_q;
	logic [11:0]                   iidx_q;
	logic [15:0]                   rating_q;
	uimp_pkg::entry_t              uent_q;
	uimp_pkg::entry_t              ient_q;
	logic [39:0]                   gsum_q;
	logic [23:0]                   gcnt_q;
	logic [uimp_pkg::CLR_W-1:0]    clr_cnt_q;
	logic [15:0]                   pred_q;
	logic [1:0]                    status_q;

	logic [15:0]                   u_ext_in, u_ext_q, i_ext_in, i_ext_q;
	logic [uimp_pkg::USER_AW-1:0]  u_addr_in, u_addr_q, u_clr_addr;
	logic [uimp_pkg::ITEM_AW-1:0]  i_addr_in, i_addr_q, i_clr_addr;
	logic                          u_clr_en;
	logic                          u_ok, i_ok;
	uimp_pkg::entry_t              u_new, i_new;
	logic [15:0]                   gq, uq, iq, um, im;
	logic                          g_done, u_done, i_done;
	logic [16:0]                   pred_sum;

	assign u_ext_in   = {6'b0, user_index};
	assign i_ext_in   = {4'b0, item_index};
	assign u_ext_q    = {6'b0, uidx_q};
	assign i_ext_q    = {4'b0, iidx_q};
	assign u_addr_in  = u_ext_in[uimp_pkg::USER_AW-1:0];
	assign i_addr_in  = i_ext_in[uimp_pkg::ITEM_AW-1:0];
	assign u_addr_q   = u_ext_q[uimp_pkg::USER_AW-1:0];
	assign i_addr_q   = i_ext_q[uimp_pkg::ITEM_AW-1:0];
	assign u_clr_addr = clr_cnt_q[uimp_pkg::USER_AW-1:0];
	assign i_clr_addr = clr_cnt_q[uimp_pkg::ITEM_AW-1:0];
	assign u_clr_en   = 32'(clr_cnt_q) < uimp_pkg::NUM_USERS;
	assign u_ok       = 32'(uidx_q) < uimp_pkg::NUM_USERS;
	assign i_ok       = 32'(iidx_q) < uimp_pkg::NUM_ITEMS;

	assign u_new.sum = uent_q.sum + 32'(rating_q);
	assign u_new.cnt = uent_q.cnt + 16'd1;
	assign i_new.sum = ient_q.sum + 32'(rating_q);
	assign i_new.cnt = ient_q.cnt + 16'd1;

	always_ff @(posedge clk) begin
		if (cmd.clear_step && u_clr_en)
			user_mem[u_clr_addr] <= '0;
		else if (cmd.write_add)
			user_mem[u_addr_q] <= u_new;
		if (cmd.capture)
			uent_q <= user_mem[u_addr_in];
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step)
			item_mem[i_clr_addr] <= '0;
		else if (cmd.write_add)
			item_mem[i_addr_q] <= i_new;
		if (cmd.capture)
			ient_q <= item_mem[i_addr_in];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			uidx_q   <= user_index;
			iidx_q   <= item_index;
			rating_q <= rating;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsum_q    <= '0;
			gcnt_q    <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.write_add) begin
				gsum_q <= gsum_q + 40'(rating_q);
				gcnt_q <= gcnt_q + 24'd1;
			end
			if (cmd.clear_step && !stat.clr_last)
				clr_cnt_q <= clr_cnt_q + uimp_pkg::CLR_W'(1);
		end
	end

	uimp_div u_div_g (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (gsum_q),
		.divisor  (gcnt_q),
		.quotient (gq),
		.done     (g_done)
	);

	uimp_div u_div_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({8'b0, uent_q.sum}),
		.divisor  ({8'b0, uent_q.cnt}),
		.quotient (uq),
		.done     (u_done)
	);

	uimp_div u_div_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({8'b0, ient_q.sum}),
		.divisor  ({8'b0, ient_q.cnt}),
		.quotient (iq),
		.done     (i_done)
	);

	assign um       = (u_ok && uent_q.cnt != 16'd0) ? uq : gq;
	assign im       = (i_ok && ient_q.cnt != 16'd0) ? iq : gq;
	assign pred_sum = {1'b0, um} + {1'b0, im};

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				uimp_pkg::RES_ADD_OK: begin
					pred_q   <= '0;
					status_q <= uimp_pkg::ST_OK;
				end
				uimp_pkg::RES_REFUSED: begin
					pred_q   <= '0;
					status_q <= uimp_pkg::ST_REFUSED;
				end
				uimp_pkg::RES_EMPTY: begin
					pred_q   <= '0;
					status_q <= uimp_pkg::ST_EMPTY;
				end
				uimp_pkg::RES_PRED: begin
					pred_q   <= pred_sum[16:1];
					status_q <= uimp_pkg::ST_OK;
				end
			endcase
		end
	end

	assign stat.clr_last    = clr_cnt_q == uimp_pkg::CLR_W'(uimp_pkg::CLR_N - 1);
	assign stat.is_query    = op_q == uimp_pkg::OP_QUERY;
	assign stat.refuse      = !u_ok || !i_ok ||
	                          uent_q.cnt == uimp_pkg::COUNT_MAX ||
	                          ient_q.cnt == uimp_pkg::COUNT_MAX ||
	                          gcnt_q == uimp_pkg::GCOUNT_MAX;
	assign stat.gcount_zero = gcnt_q == 24'd0;
	assign stat.div_done    = g_done & u_done & i_done;

	assign prediction = pred_q;
	assign status     = status_q;

endmodule

### rtl/uimp_ctrl.sv
module uimp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  uimp_pkg::stat_t  stat,
	output uimp_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_DIV
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					if (!stat.is_query || stat.gcount_zero) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (stat.div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.res_sel    = uimp_pkg::RES_ADD_OK;
		cmd.clear_step = state_q == S_CLEAR;
		cmd.capture    = state_q == S_IDLE && start;
		if (state_q == S_LOOK) begin
			if (!stat.is_query) begin
				cmd.res_load  = 1'b1;
				cmd.write_add = !stat.refuse;
				cmd.res_sel   = stat.refuse ? uimp_pkg::RES_REFUSED : uimp_pkg::RES_ADD_OK;
			end else if (stat.gcount_zero) begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = uimp_pkg::RES_EMPTY;
			end else begin
				cmd.div_start = 1'b1;
			end
		end
		if (state_q == S_DIV && stat.div_done) begin
			cmd.res_load = 1'b1;
			cmd.res_sel  = uimp_pkg::RES_PRED;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_IDLE))
		else $error("result strobe outside idle");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	a_no_refused_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_add |-> (!stat.refuse && state_q == S_LOOK))
		else $error("store write on refused word");

endmodule
